FILE: hw/rtl/ibfa_pkg.sv
// Shared types, constants and the CRC-8 byte update for the IMU burst frame assembler.
// No dependencies; every other file of the block imports this package.
package ibfa_pkg;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [3:0] LEN_SIX   = 4'd14;
    localparam logic [3:0] LEN_THREE = 4'd6;
    localparam int         STORE_DEPTH = 14;

    localparam logic KIND_SIX_AXIS   = 1'b0;
    localparam logic KIND_THREE_AXIS = 1'b1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] temp_reading;
        logic [31:0]        sample_seq;
        logic [7:0]         frame_crc;
        logic [31:0]        sample_time;
    } sample_t;

    typedef struct packed {
        logic last_pending;
        logic fire;
    } asm_stat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/imu_burst_frame_assembler_core.sv
// IMU burst frame assembler: one received byte per beat, one decoded sample per frame.
// A last byte taken with cfg_write low puts its sample on out_valid in the next cycle.
// Throughput: one byte per cycle; any byte offered while the position is a frame's last
// waits only while the output register holds an untaken sample; others are always taken.
// Reset: six-axis mode, byte position 0, CRC 0xFF, sequence 0, output empty; the
// frame store is not cleared. Depends on ibfa_pkg, ibfa_assemble, ibfa_out_stage.
module imu_burst_frame_assembler_core
    import ibfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_begin,
    input  logic [31:0]        now_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] accel_x,
    output logic signed [15:0] accel_y,
    output logic signed [15:0] accel_z,
    output logic signed [15:0] gyro_x,
    output logic signed [15:0] gyro_y,
    output logic signed [15:0] gyro_z,
    output logic signed [15:0] temp_reading,
    output logic [31:0]        sample_seq,
    output logic [7:0]         frame_crc,
    output logic [31:0]        sample_time
);

    sample_t   sample_new;
    sample_t   sample_held;
    asm_stat_t stat;
    logic      take;

    assign in_ready = !out_valid || out_ready || !stat.last_pending;
    assign take     = in_valid && in_ready;

    ibfa_assemble u_assemble (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .take        (take),
        .rx_byte     (rx_byte),
        .frame_begin (frame_begin),
        .now_time    (now_time),
        .sample      (sample_new),
        .stat        (stat)
    );

    ibfa_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (stat.fire && !cfg_write),
        .sample_in  (sample_new),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .sample_out (sample_held)
    );

    assign accel_x      = sample_held.accel_x;
    assign accel_y      = sample_held.accel_y;
    assign accel_z      = sample_held.accel_z;
    assign gyro_x       = sample_held.gyro_x;
    assign gyro_y       = sample_held.gyro_y;
    assign gyro_z       = sample_held.gyro_z;
    assign temp_reading = sample_held.temp_reading;
    assign sample_seq   = sample_held.sample_seq;
    assign frame_crc    = sample_held.frame_crc;
    assign sample_time  = sample_held.sample_time;

endmodule

FILE: hw/rtl/ibfa_assemble.sv
// Byte capture, frame store, running CRC-8 and sample decode.
// Depends on ibfa_pkg.
module ibfa_assemble
    import ibfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        take,
    input  logic [7:0]  rx_byte,
    input  logic        frame_begin,
    input  logic [31:0] now_time,
    output sample_t     sample,
    output asm_stat_t   stat
);

    logic        kind_reg;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic [31:0] seq_reg;
    logic [31:0] seq_next;
    logic [7:0]  store_reg [STORE_DEPTH];

    logic [3:0]  frame_len;
    logic [3:0]  pos_eff;
    logic [7:0]  crc_base;
    logic [7:0]  crc_new;
    logic        done;

    assign frame_len = (kind_reg == KIND_THREE_AXIS) ? LEN_THREE : LEN_SIX;
    assign pos_eff   = frame_begin ? 4'd0 : pos_reg;
    assign crc_base  = frame_begin ? CRC_INIT : crc_reg;
    assign crc_new   = crc8_byte(crc_base, rx_byte);
    assign done      = (pos_eff == frame_len - 4'd1);

    assign stat.last_pending = (pos_reg == frame_len - 4'd1);
    assign stat.fire         = take && done;

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        seq_next = seq_reg;
        if (cfg_write)
        begin
            pos_next = 4'd0;
            crc_next = CRC_INIT;
        end
        else if (take)
        begin
            if (done)
            begin
                pos_next = 4'd0;
                crc_next = CRC_INIT;
                seq_next = seq_reg + 32'd1;
            end
            else
            begin
                pos_next = pos_eff + 4'd1;
                crc_next = crc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_SIX_AXIS;
            pos_reg  <= 4'd0;
            crc_reg  <= CRC_INIT;
            seq_reg  <= 32'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                kind_reg <= cfg_data;
            end
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !cfg_write)
        begin
            store_reg[pos_eff] <= rx_byte;
        end
    end

    always_comb
    begin
        sample             = '0;
        sample.sample_seq  = seq_reg;
        sample.frame_crc   = crc_new;
        sample.sample_time = now_time;
        if (kind_reg == KIND_SIX_AXIS)
        begin
            sample.accel_x      = {store_reg[0],  store_reg[1]};
            sample.accel_y      = {store_reg[2],  store_reg[3]};
            sample.accel_z      = {store_reg[4],  store_reg[5]};
            sample.temp_reading = {store_reg[6],  store_reg[7]};
            sample.gyro_x       = {store_reg[8],  store_reg[9]};
            sample.gyro_y       = {store_reg[10], store_reg[11]};
            sample.gyro_z       = {store_reg[12], rx_byte};
        end
        else
        begin
            sample.accel_x = {store_reg[1], store_reg[0]};
            sample.accel_y = {store_reg[3], store_reg[2]};
            sample.accel_z = {rx_byte,      store_reg[4]};
        end
    end

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < frame_len)
        else $error("byte position beyond frame length");

    a_restart_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire && !cfg_write |=> pos_reg == 4'd0 && crc_reg == CRC_INIT)
        else $error("frame state not restarted after completed frame");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire && !cfg_write |=> seq_reg == $past(seq_reg) + 32'd1)
        else $error("sequence number did not advance on completed frame");

endmodule

FILE: hw/rtl/ibfa_out_stage.sv
// Output register holding one finished sample until the consumer takes the beat.
// Depends on ibfa_pkg.
module ibfa_out_stage
    import ibfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  sample_t sample_in,
    input  logic    out_ready,
    output logic    out_valid,
    output sample_t sample_out
);

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;

    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign sample_out = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_in;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || out_ready)
        else $error("pending sample overwritten");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && !load |=> !valid_reg)
        else $error("sample delivered twice");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg)
        else $error("pending sample dropped");

endmodule

FILE: tb/tb_imu_burst_frame_assembler_core.sv
// Self-checking testbench for imu_burst_frame_assembler_core: bytes in, decoded samples out.
// A directed table, then random framed bursts, are checked against a behavioral assembler.
// Depends on ibfa_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module tb_imu_burst_frame_assembler_core;
    import ibfa_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_PAD   = 4;
    localparam int END_PAD     = 12;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 112;

    typedef struct {
        logic        kind;
        logic [7:0]  b;
        logic        bg;
        logic [31:0] t;
        bit          pin;
        sample_t     exp;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               frame_begin;
    logic [31:0]        now_time;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] temp_reading;
    logic [31:0]        sample_seq;
    logic [7:0]         frame_crc;
    logic [31:0]        sample_time;

    // behavioral assembler state
    logic        asm_kind = KIND_SIX_AXIS;
    logic [3:0]  asm_pos  = 4'd0;
    logic [7:0]  asm_crc  = CRC_INIT;
    logic [31:0] asm_seq  = 32'd0;
    logic [7:0]  asm_store [STORE_DEPTH];

    sample_t  pending_samples [$];
    dir_row_t dir_rows [$];
    int       mismatches = 0;
    bit       pin_armed  = 0;
    sample_t  pin_sample;
    bit       hold_req   = 0;
    int       burst_left = 0;
    int       frame_pos  = 0;
    logic     cur_kind   = KIND_SIX_AXIS;

    imu_burst_frame_assembler_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .frame_begin  (frame_begin),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .gyro_x       (gyro_x),
        .gyro_y       (gyro_y),
        .gyro_z       (gyro_z),
        .temp_reading (temp_reading),
        .sample_seq   (sample_seq),
        .frame_crc    (frame_crc),
        .sample_time  (sample_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic assemble_byte(input logic [7:0] b, input logic bg, input logic [31:0] t,
                                 output bit made, output sample_t s);
        logic [3:0] flen;
        logic [3:0] p;
        logic [7:0] c;
        flen = (asm_kind == KIND_THREE_AXIS) ? LEN_THREE : LEN_SIX;
        made = 1'b0;
        s = '0;
        if (bg)
        begin
            asm_pos = 4'd0;
            asm_crc = CRC_INIT;
        end
        p = asm_pos;
        if (p >= flen)
        begin
            p = 4'd0;
            asm_crc = CRC_INIT;
        end
        asm_store[p] = b;
        c = crc8_next(asm_crc, b);
        if (p + 1 < flen)
        begin
            asm_pos = p + 4'd1;
            asm_crc = c;
        end
        else
        begin
            made = 1'b1;
            if (asm_kind == KIND_SIX_AXIS)
            begin
                s.accel_x      = {asm_store[0], asm_store[1]};
                s.accel_y      = {asm_store[2], asm_store[3]};
                s.accel_z      = {asm_store[4], asm_store[5]};
                s.temp_reading = {asm_store[6], asm_store[7]};
                s.gyro_x       = {asm_store[8], asm_store[9]};
                s.gyro_y       = {asm_store[10], asm_store[11]};
                s.gyro_z       = {asm_store[12], asm_store[13]};
            end
            else
            begin
                s.accel_x = {asm_store[1], asm_store[0]};
                s.accel_y = {asm_store[3], asm_store[2]};
                s.accel_z = {asm_store[5], asm_store[4]};
            end
            s.sample_seq  = asm_seq;
            s.frame_crc   = c;
            s.sample_time = t;
            asm_seq = asm_seq + 32'd1;
            asm_pos = 4'd0;
            asm_crc = CRC_INIT;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, actual %0h", name, e, a);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        sample_t want;
        sample_t got;
        bit      made;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("sample seq %0h arrived with no sample expected", sample_seq);
                    mismatches++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    check_field("accel_x", 32'(want.accel_x), 32'(accel_x));
                    check_field("accel_y", 32'(want.accel_y), 32'(accel_y));
                    check_field("accel_z", 32'(want.accel_z), 32'(accel_z));
                    check_field("gyro_x", 32'(want.gyro_x), 32'(gyro_x));
                    check_field("gyro_y", 32'(want.gyro_y), 32'(gyro_y));
                    check_field("gyro_z", 32'(want.gyro_z), 32'(gyro_z));
                    check_field("temp_reading", 32'(want.temp_reading), 32'(temp_reading));
                    check_field("sample_seq", want.sample_seq, sample_seq);
                    check_field("frame_crc", 32'(want.frame_crc), 32'(frame_crc));
                    check_field("sample_time", want.sample_time, sample_time);
                end
            end
            if (cfg_write)
            begin
                asm_kind = cfg_data;
                asm_pos  = 4'd0;
                asm_crc  = CRC_INIT;
            end
            if (in_valid && in_ready)
            begin
                assemble_byte(rx_byte, frame_begin, now_time, made, got);
                if (made && pin_armed)
                begin
                    // CRC stays with the assembler; everything else is the typed value
                    got.accel_x      = pin_sample.accel_x;
                    got.accel_y      = pin_sample.accel_y;
                    got.accel_z      = pin_sample.accel_z;
                    got.gyro_x       = pin_sample.gyro_x;
                    got.gyro_y       = pin_sample.gyro_y;
                    got.gyro_z       = pin_sample.gyro_z;
                    got.temp_reading = pin_sample.temp_reading;
                    got.sample_seq   = pin_sample.sample_seq;
                    got.sample_time  = pin_sample.sample_time;
                end
                else if (pin_armed)
                begin
                    $error("directed row expected a sample, frame not complete");
                    mismatches++;
                end
                if (made)
                begin
                    pending_samples.push_back(got);
                end
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int left;
        int hold;
        out_ready = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold = 119;
                out_ready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 80);
                end
                left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("tb_imu_burst_frame_assembler_core: FAIL");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_stamp();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [7:0] b, input logic bg, input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_begin <= bg;
        now_time    <= t;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_kind(input logic k);
        drain();
        repeat (DRAIN_PAD) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= k;
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_kind  = k;
        frame_pos = 0;
    endtask

    task automatic add_row(input logic kind, input logic [7:0] b, input logic bg,
                           input logic [31:0] t, input bit pin, input sample_t exp);
        dir_row_t row;
        row.kind = kind;
        row.b    = b;
        row.bg   = bg;
        row.t    = t;
        row.pin  = pin;
        row.exp  = exp;
        dir_rows.push_back(row);
    endtask

    initial
    begin
        sample_t     pinned;
        logic [7:0]  six_bytes [14];
        logic [7:0]  three_bytes [6];
        int          phase;
        int          sent;
        int          sel;
        int          n;
        int          flen;
        logic        k;
        logic        bg;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        frame_begin = 1'b0;
        now_time    = 32'h0;

        // partial frame, dropped by a start flag on the fourth byte
        pinned = '0;
        add_row(KIND_SIX_AXIS, 8'h12, 1'b1, 32'd0, 0, pinned);
        add_row(KIND_SIX_AXIS, 8'h34, 1'b0, 32'd1, 0, pinned);
        add_row(KIND_SIX_AXIS, 8'h56, 1'b0, 32'd2, 0, pinned);
        six_bytes = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01,
                      8'h00, 8'h00, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        for (int i = 0; i < 13; i++)
        begin
            add_row(KIND_SIX_AXIS, six_bytes[i], i == 0, 32'(3 + i), 0, pinned);
        end
        pinned.accel_x      = 16'sh8000;
        pinned.accel_y      = 16'sh7FFF;
        pinned.accel_z      = 16'shFFFF;
        pinned.temp_reading = 16'sh8001;
        pinned.gyro_x       = 16'sh0000;
        pinned.gyro_y       = 16'sh7FFE;
        pinned.gyro_z       = 16'sh55AA;
        pinned.sample_seq   = 32'd0;
        pinned.sample_time  = 32'hFFFF_FFFF;
        add_row(KIND_SIX_AXIS, six_bytes[13], 1'b0, 32'hFFFF_FFFF, 1, pinned);

        // three-axis frame with no start flag after the mode write
        pinned = '0;
        three_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00};
        for (int i = 0; i < 5; i++)
        begin
            add_row(KIND_THREE_AXIS, three_bytes[i], 1'b0, 32'(16 + i), 0, pinned);
        end
        pinned.accel_x     = 16'sh8000;
        pinned.accel_y     = 16'sh7FFF;
        pinned.accel_z     = 16'sh0001;
        pinned.sample_seq  = 32'd1;
        pinned.sample_time = 32'h0000_0000;
        add_row(KIND_THREE_AXIS, three_bytes[5], 1'b0, 32'h0000_0000, 1, pinned);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind != cur_kind)
            begin
                set_kind(dir_rows[r].kind);
            end
            pin_armed  <= dir_rows[r].pin;
            pin_sample <= dir_rows[r].exp;
            send_item(dir_rows[r].b, dir_rows[r].bg, dir_rows[r].t);
        end
        pin_armed <= 0;
        frame_pos = 0;

        for (phase = 0; phase < PHASES; phase++)
        begin
            k = (phase < 2) ? ~phase[0] : 1'($urandom_range(0, 1));
            if (k != cur_kind || $urandom_range(0, 1) == 1)
            begin
                set_kind(k);
            end
            if (phase == 2)
            begin
                hold_req = 1;
            end
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                flen = (cur_kind == KIND_THREE_AXIS) ? 6 : 14;
                sel = $urandom_range(0, 99);
                if (sel < 70)
                begin
                    for (int i = 0; i < flen; i++)
                    begin
                        bg = (i == 0) && (frame_pos != 0 || $urandom_range(0, 1) == 1);
                        send_item(rand_byte(), bg, rand_stamp());
                    end
                    frame_pos = 0;
                    sent += flen;
                end
                else if (sel < 85)
                begin
                    n = $urandom_range(1, flen - 1);
                    for (int i = 0; i < n; i++)
                    begin
                        send_item(rand_byte(), i == 0, rand_stamp());
                    end
                    frame_pos = n;
                    sent += n;
                end
                else
                begin
                    bg = 1'($urandom_range(0, 1));
                    send_item(rand_byte(), bg, rand_stamp());
                    frame_pos = bg ? 1 : frame_pos + 1;
                    if (frame_pos == flen)
                    begin
                        frame_pos = 0;
                    end
                    sent++;
                end
            end
            if (phase == 4)
            begin
                drain();
            end
        end

        drain();
        repeat (END_PAD) @(negedge clk);
        if (mismatches == 0 && pending_samples.size() == 0)
        begin
            $display("tb_imu_burst_frame_assembler_core: PASS");
        end
        else
        begin
            $display("tb_imu_burst_frame_assembler_core: FAIL");
        end
        $finish;
    end

endmodule
